@@ design/urlpd_pkg.sv @@
// Package for the URL percent decoder: character codes, phase encoding,
// result and decode-step structs, hex digit helper. No dependencies.
package urlpd_pkg;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTwo   = 8'h32;

  localparam logic CfgSlashDecode = 1'b0;
  localparam logic CfgPlusAsSpace = 1'b1;

  typedef enum logic [3:0] {
    PH_NORMAL  = 4'b0001,
    PH_PCT     = 4'b0010,
    PH_DIG     = 4'b0100,
    PH_SWALLOW = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       failed;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res;
    phase_e     nxt_phase;
    logic [3:0] nxt_nibble;
  } dec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ design/urlpd_decode.sv @@
// Combinational decode step of the URL percent decoder: one held item,
// phase and result slot in, one result, count and next phase out. Uses urlpd_pkg.
module urlpd_decode (
  input  urlpd_pkg::phase_e phase_i,
  input  logic [3:0]        nibble_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic [1:0]        sub_i,
  input  logic              slash_decode_i,
  input  logic              plus_as_space_i,
  output urlpd_pkg::dec_t   dec_o
);
  import urlpd_pkg::*;

  hex_t       hex;
  logic [7:0] val;
  res_t       fail_res;

  assign hex      = hex_value(in_byte_i);
  assign val      = {nibble_i, hex.val};
  assign fail_res = '{out_byte: 8'h00, run_last: 1'b1, string_end: 1'b1, failed: 1'b1};

  always_comb begin
    dec_o.cnt        = 2'd0;
    dec_o.res        = fail_res;
    dec_o.nxt_phase  = phase_i;
    dec_o.nxt_nibble = nibble_i;
    case (phase_i)
      PH_NORMAL: begin
        if (in_byte_i == CharPct) begin
          if (in_last_i) begin
            dec_o.cnt        = 2'd1;
            dec_o.nxt_nibble = 4'h0;
          end else begin
            dec_o.nxt_phase = PH_PCT;
          end
        end else begin
          dec_o.cnt = 2'd1;
          dec_o.res = '{out_byte:   (in_byte_i == CharPlus && plus_as_space_i) ?
                                    CharSpace : in_byte_i,
                        run_last:   1'b1,
                        string_end: in_last_i,
                        failed:     1'b0};
        end
      end
      PH_PCT: begin
        if (!hex.ok || in_last_i) begin
          dec_o.cnt        = 2'd1;
          dec_o.nxt_phase  = in_last_i ? PH_NORMAL : PH_SWALLOW;
          dec_o.nxt_nibble = 4'h0;
        end else begin
          dec_o.nxt_phase  = PH_DIG;
          dec_o.nxt_nibble = hex.val;
        end
      end
      PH_DIG: begin
        dec_o.cnt        = 2'd1;
        dec_o.nxt_nibble = 4'h0;
        if (!hex.ok) begin
          dec_o.nxt_phase = in_last_i ? PH_NORMAL : PH_SWALLOW;
        end else begin
          dec_o.nxt_phase = PH_NORMAL;
          if (val == CharSlash && !slash_decode_i) begin
            // keep the escape text: '%', '2', then the digit as received
            dec_o.cnt = 2'd3;
            case (sub_i)
              2'd0:    dec_o.res = '{CharPct, 1'b0, 1'b0, 1'b0};
              2'd1:    dec_o.res = '{CharTwo, 1'b0, 1'b0, 1'b0};
              default: dec_o.res = '{in_byte_i, 1'b1, in_last_i, 1'b0};
            endcase
          end else begin
            dec_o.res = '{val, 1'b1, in_last_i, 1'b0};
          end
        end
      end
      PH_SWALLOW: begin
        if (in_last_i) dec_o.nxt_phase = PH_NORMAL;
      end
      default: begin
        dec_o.nxt_phase  = PH_NORMAL;
        dec_o.nxt_nibble = 4'h0;
      end
    endcase
  end

endmodule

@@ design/urlpd_out_stage.sv @@
// Result register of the URL percent decoder with valid/stall handshake.
// Uses urlpd_pkg for the result struct.
module urlpd_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  urlpd_pkg::res_t res_i,
  output logic            ready_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output urlpd_pkg::res_t res_o
);
  import urlpd_pkg::*;

  logic valid_q;
  res_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) res_q <= res_i;
  end

endmodule

@@ design/url_percent_decoder.sv @@
// Top level of the URL percent decoder: input register, decode step,
// result register. Depends on urlpd_pkg, urlpd_decode and urlpd_out_stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one character item with
//   in_byte_i and in_last_i; in_last_i marks the end of a string. The output
//   channel (out_valid_o / out_stall_i) carries result items: out_byte_o,
//   run_last_o, string_end_o and failed_o. An item moves at a rising edge
//   with valid high and stall low.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 slash_decode, 1 plus_as_space); write only while the block is idle.
//   An item taken sits in the input register, and its first result, if it
//   has one, is loaded from there into the result register once that has
//   room, so it is offered on the output from then on.
//   Throughput: one item per cycle while the output does not stall. An escape
//   decoding to a slash that is kept as text gives three results and holds the
//   input register until its last result slot goes out; that single register limits the rate.
//   Reset clears the phase to normal, the config bits and all valid flags.
//   When the receiver stalls, the result register holds; the input register
//   then holds an item that has a result to give, and in_stall_o rises until room returns.
module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [0:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       failed_o
);
  import urlpd_pkg::*;

  // configuration
  logic slash_decode_q, plus_as_space_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // decode state
  phase_e     phase_q;
  logic [3:0] nibble_q;
  logic [1:0] sub_q;

  dec_t dec;
  res_t out_res;
  logic out_ready;
  logic emit;
  logic item_done;
  logic in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slash_decode_q  <= 1'b0;
      plus_as_space_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i[0])
        CfgSlashDecode: slash_decode_q  <= cfg_data_i[0];
        CfgPlusAsSpace: plus_as_space_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  urlpd_decode u_decode (
    .phase_i         (phase_q),
    .nibble_i        (nibble_q),
    .in_byte_i       (in_byte_q),
    .in_last_i       (in_last_q),
    .sub_i           (sub_q),
    .slash_decode_i  (slash_decode_q),
    .plus_as_space_i (plus_as_space_q),
    .dec_o           (dec)
  );

  // Emit one result slot per cycle while the result register has room;
  // retire the item once its last slot goes out, or at once if it has none.
  assign emit      = in_valid_q && (dec.cnt != 2'd0) && out_ready;
  assign item_done = in_valid_q &&
                     ((dec.cnt == 2'd0) || (emit && (sub_q == dec.cnt - 2'd1)));
  assign in_stall_o = in_valid_q && !item_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_NORMAL;
      nibble_q   <= 4'h0;
      sub_q      <= 2'd0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (item_done) begin
        in_valid_q <= 1'b0;
      end
      if (item_done) begin
        phase_q  <= dec.nxt_phase;
        nibble_q <= dec.nxt_nibble;
        sub_q    <= 2'd0;
      end else if (emit) begin
        sub_q <= sub_q + 2'd1;
      end
    end
  end

  // hold the payload while the item is in progress
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  urlpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .res_i       (dec.res),
    .ready_o     (out_ready),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign run_last_o   = out_res.run_last;
  assign string_end_o = out_res.string_end;
  assign failed_o     = out_res.failed;

endmodule
